// ----- rtl/ehp_pkg.sv -----
package ehp_pkg;

  // frame geometry
  localparam int MAX_DIM = 1024;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int SIZE_W  = DIM_W + 1;
  localparam int MIN_DIM = 3;

  // sample and bin widths
  localparam int LUMA_W = 8;
  localparam int THR_W  = 8;
  localparam int BIN_W  = 18;
  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

  // line buffer word: previous row in the upper half, row before it in the lower half
  localparam int LINE_W = 2 * LUMA_W;

  // register map
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(320);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(240);

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef enum logic {
    DIR_COLUMN = 1'b0,
    DIR_ROW    = 1'b1
  } dir_t;

  typedef struct packed {
    cmd_t              command;
    logic [LUMA_W-1:0] luma;
    logic              frame_start;
    logic [DIM_W-1:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_value;
    logic [DIM_W-1:0] bin_number;
  } rsp_t;

  typedef struct packed {
    dir_t              direction;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [THR_W-1:0]  thresh;
  } cfg_t;

  // position and bin target of the pixel being accepted
  typedef struct packed {
    logic [DIM_W-1:0]  x;
    logic [DIM_W-1:0]  bin;
    logic              add_en;
    logic              first;
    logic [LUMA_W-1:0] left_left;
  } pos_t;

  // frame size limited to the supported range
  function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(MIN_DIM)) begin
      r = SIZE_W'(MIN_DIM);
    end else if (v > SIZE_W'(MAX_DIM)) begin
      r = SIZE_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/ehp_ram.sv -----
module ehp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q;
  logic [WIDTH-1:0] fwd_data;
  logic             fwd;

  // storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q        <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // a read that collides with a write in the same cycle takes the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : q;

endmodule

// ----- rtl/ehp_cfg_regs.sv -----
module ehp_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ehp_pkg::APB_AW-1:0] paddr,
  input  logic [ehp_pkg::APB_DW-1:0] pwdata,
  output logic [ehp_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output ehp_pkg::cfg_t              cfg
);

  ehp_pkg::reg_t sel;
  logic          wr;

  assign sel    = ehp_pkg::reg_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction <= ehp_pkg::DIR_COLUMN;
      cfg.width     <= ehp_pkg::WIDTH_RESET;
      cfg.height    <= ehp_pkg::HEIGHT_RESET;
      cfg.thresh    <= '0;
    end else if (wr) begin
      case (sel)
        ehp_pkg::REG_DIRECTION: cfg.direction <= ehp_pkg::dir_t'(pwdata[0]);
        ehp_pkg::REG_WIDTH:     cfg.width     <= pwdata[ehp_pkg::SIZE_W-1:0];
        ehp_pkg::REG_HEIGHT:    cfg.height    <= pwdata[ehp_pkg::SIZE_W-1:0];
        ehp_pkg::REG_THRESHOLD: cfg.thresh    <= pwdata[ehp_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (sel)
      ehp_pkg::REG_DIRECTION: prdata = ehp_pkg::APB_DW'(cfg.direction);
      ehp_pkg::REG_WIDTH:     prdata = ehp_pkg::APB_DW'(cfg.width);
      ehp_pkg::REG_HEIGHT:    prdata = ehp_pkg::APB_DW'(cfg.height);
      ehp_pkg::REG_THRESHOLD: prdata = ehp_pkg::APB_DW'(cfg.thresh);
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- rtl/ehp_scan.sv -----
module ehp_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic [ehp_pkg::LUMA_W-1:0] luma,
  input  logic                       frame_start,
  input  ehp_pkg::cfg_t              cfg,
  output ehp_pkg::pos_t              pos
);

  logic [ehp_pkg::DIM_W-1:0]  col_count;
  logic [ehp_pkg::DIM_W-1:0]  row_count;
  logic [ehp_pkg::LUMA_W-1:0] left_pixel;
  logic [ehp_pkg::LUMA_W-1:0] left_left_pixel;
  logic [ehp_pkg::SIZE_W-1:0] w, h;
  logic [ehp_pkg::SIZE_W-1:0] x0, y0, xa, ya, xn, yn;

  assign w = ehp_pkg::clamp_dim(cfg.width);
  assign h = ehp_pkg::clamp_dim(cfg.height);

  // position of this pixel and of the next one, with row and frame wrap
  always_comb begin
    x0 = frame_start ? '0 : {1'b0, col_count};
    y0 = frame_start ? '0 : {1'b0, row_count};
    if (x0 >= w) begin
      xa = '0;
      ya = y0 + 1'b1;
    end else begin
      xa = x0;
      ya = y0;
    end
    if (ya >= h) begin
      ya = '0;
    end
    xn = xa + 1'b1;
    yn = ya;
    if (xn >= w) begin
      xn = '0;
      yn = ya + 1'b1;
      if (yn >= h) begin
        yn = '0;
      end
    end
  end

  // bin target: column bins from the horizontal neighbors, row bins from the vertical ones
  always_comb begin
    pos.x         = xa[ehp_pkg::DIM_W-1:0];
    pos.left_left = left_left_pixel;
    if (cfg.direction == ehp_pkg::DIR_COLUMN) begin
      pos.add_en = xa >= ehp_pkg::SIZE_W'(2);
      pos.bin    = ehp_pkg::DIM_W'(xa - 1'b1);
      pos.first  = ya == '0;
    end else begin
      pos.add_en = ya >= ehp_pkg::SIZE_W'(2);
      pos.bin    = ehp_pkg::DIM_W'(ya - 1'b1);
      pos.first  = xa == '0;
    end
  end

  // scan position and horizontal neighbors
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count       <= '0;
      row_count       <= '0;
      left_pixel      <= '0;
      left_left_pixel <= '0;
    end else if (adv) begin
      col_count       <= xn[ehp_pkg::DIM_W-1:0];
      row_count       <= yn[ehp_pkg::DIM_W-1:0];
      left_pixel      <= luma;
      left_left_pixel <= left_pixel;
    end
  end

endmodule

// ----- rtl/edge_histogram_projection_unit.sv -----
// Edge histogram projection. Takes one item per clock: a pixel sample in raster order, or
// a read of one bin. Each pixel reads the 1024-entry bin memory, writing it only when it has
// a bin target, and does a read-modify-write of a 1024-entry line buffer holding the two
// previous rows. An item is read from memory in its accept cycle and finishes in the stage 2
// register; a read result then passes the result register to rsp. Back-to-back hits on the
// same bin are forwarded. The request side stalls only while a read result is waiting behind
// an earlier result that rsp holds. Bins 0, size-1 and beyond read as zero; sums saturate at
// 262143. The frame size and mode registers may be changed only with no items in flight.
module edge_histogram_projection_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  ehp_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output ehp_pkg::rsp_t              rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ehp_pkg::APB_AW-1:0] paddr,
  input  logic [ehp_pkg::APB_DW-1:0] pwdata,
  output logic [ehp_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  ehp_pkg::cfg_t cfg;
  ehp_pkg::pos_t pos;

  logic req_acc, pix_acc;
  logic [ehp_pkg::SIZE_W-1:0] size;
  logic rd_ok;

  // second stage
  logic                       s2_valid;
  logic                       s2_read;
  logic                       s2_add_en;
  logic                       s2_first;
  logic                       s2_rd_ok;
  logic [ehp_pkg::LUMA_W-1:0] s2_luma;
  logic [ehp_pkg::LUMA_W-1:0] s2_left_left;
  logic [ehp_pkg::DIM_W-1:0]  s2_x;
  logic [ehp_pkg::DIM_W-1:0]  s2_bin;
  logic                       s2_done;

  logic [ehp_pkg::LINE_W-1:0] line_rd, line_wr;
  logic [ehp_pkg::BIN_W-1:0]  bin_rd, bin_wr;
  logic [ehp_pkg::DIM_W-1:0]  bin_rd_addr;
  logic                       bin_we, line_we;
  logic [ehp_pkg::LUMA_W-1:0] ref_pix, grad, contrib;
  logic [ehp_pkg::BIN_W:0]    sum;

  ehp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: only a read result blocked behind a stalled result holds the pipe
  assign s2_done   = s2_valid && (!s2_read || !rsp_valid || !rsp_stall);
  assign req_stall = s2_valid && !s2_done;
  assign req_acc   = req_valid && !req_stall;
  assign pix_acc   = req_acc && (req.command == ehp_pkg::CMD_PIXEL);

  ehp_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .adv         (pix_acc),
    .luma        (req.luma),
    .frame_start (req.frame_start),
    .cfg         (cfg),
    .pos         (pos)
  );

  // read bounds: interior bins of the active size only
  assign size  = (cfg.direction == ehp_pkg::DIR_ROW) ? ehp_pkg::clamp_dim(cfg.height)
                                                    : ehp_pkg::clamp_dim(cfg.width);
  assign rd_ok = (req.read_index != '0) && (({1'b0, req.read_index} + 1'b1) < size);

  assign bin_rd_addr = (req.command == ehp_pkg::CMD_READ) ? req.read_index : pos.bin;

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (req_acc) begin
      s2_valid <= 1'b1;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s2_read      <= req.command == ehp_pkg::CMD_READ;
      s2_add_en    <= pos.add_en;
      s2_first     <= pos.first;
      s2_rd_ok     <= rd_ok;
      s2_luma      <= req.luma;
      s2_left_left <= pos.left_left;
      s2_x         <= pos.x;
      s2_bin       <= bin_rd_addr;
    end
  end

  // line buffer: shift this column down one row
  assign line_we = s2_valid && !s2_read;
  assign line_wr = {s2_luma, line_rd[ehp_pkg::LINE_W-1:ehp_pkg::LUMA_W]};

  ehp_ram #(
    .WIDTH (ehp_pkg::LINE_W),
    .DEPTH (ehp_pkg::MAX_DIM)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (pix_acc),
    .rd_addr (pos.x),
    .rd_data (line_rd),
    .wr_en   (line_we),
    .wr_addr (s2_x),
    .wr_data (line_wr)
  );

  // gradient, threshold and saturating accumulate
  always_comb begin
    ref_pix = (cfg.direction == ehp_pkg::DIR_COLUMN) ? s2_left_left
                                                     : line_rd[ehp_pkg::LUMA_W-1:0];
    grad    = (s2_luma > ref_pix) ? (s2_luma - ref_pix) : (ref_pix - s2_luma);
    contrib = (grad > cfg.thresh) ? grad : '0;
    sum     = {1'b0, bin_rd} + (ehp_pkg::BIN_W + 1)'(contrib);
    if (s2_first) begin
      bin_wr = ehp_pkg::BIN_W'(contrib);
    end else if (sum[ehp_pkg::BIN_W]) begin
      bin_wr = ehp_pkg::BIN_MAX;
    end else begin
      bin_wr = sum[ehp_pkg::BIN_W-1:0];
    end
  end

  assign bin_we = s2_valid && !s2_read && s2_add_en;

  ehp_ram #(
    .WIDTH (ehp_pkg::BIN_W),
    .DEPTH (ehp_pkg::MAX_DIM)
  ) u_bins (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (req_acc),
    .rd_addr (bin_rd_addr),
    .rd_data (bin_rd),
    .wr_en   (bin_we),
    .wr_addr (s2_bin),
    .wr_data (bin_wr)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_done && s2_read) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done && s2_read) begin
      rsp.bin_value  <= s2_rd_ok ? bin_rd : '0;
      rsp.bin_number <= s2_bin;
    end
  end

endmodule

// ----- rtl/ehp_checker.sv -----
module ehp_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input ehp_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ehp_pkg::rsp_t rsp
);

  // a held result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("result changed while stalled");

  // every new result comes from an earlier read item, through the stage 2 and result registers
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |->
      $past(req_valid && !req_stall && (req.command == ehp_pkg::CMD_READ), 2))
    else $error("result without a matching read item");

  // the request side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled with the result side free");

  // the left boundary bin always reads as zero
  a_bin0_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.bin_number == '0) |-> rsp.bin_value == '0)
    else $error("boundary bin returned a nonzero value");

endmodule

bind edge_histogram_projection_unit ehp_checker u_ehp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
